FILE: rtl/core/event_surround_inhibit_filter_unit_defines.svh
// Assertion macros shared by the surround-inhibit filter RTL.
// Depends on nothing; files that assert include it by its bare name.
`ifndef EVENT_SURROUND_INHIBIT_FILTER_UNIT_DEFINES_SVH
`define EVENT_SURROUND_INHIBIT_FILTER_UNIT_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define ESIF_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define ESIF_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/core/esif_pkg.sv
// Shared types, constants and helpers of the surround-inhibit event filter.
// Depends on nothing; used by the top level.
package esif_pkg;

    localparam int MAX_COLS  = 512;
    localparam int MAX_ROWS  = 512;
    localparam int MAP_DEPTH = MAX_COLS * MAX_ROWS;
    localparam int ADDR_W    = $clog2(MAP_DEPTH);

    localparam int X_W      = 9;
    localparam int Y_W      = 9;
    localparam int TIME_W   = 32;
    localparam int WINDOW_W = 24;
    localparam int SIZE_W   = 10;
    localparam int CFG_W    = 24;
    localparam int COORD_W  = 11;

    localparam int RING_SIZE = 8;
    localparam int RING_W    = $clog2(RING_SIZE);

    localparam logic [WINDOW_W-1:0] RESET_WINDOW = WINDOW_W'(8000);
    localparam logic [SIZE_W-1:0]   RESET_WIDTH  = SIZE_W'(512);
    localparam logic [SIZE_W-1:0]   RESET_HEIGHT = SIZE_W'(512);

    typedef logic signed [1:0]         t_offset;
    typedef logic signed [COORD_W-1:0] t_coord;
    typedef logic [ADDR_W-1:0]         t_addr;

    // Column and row offsets of the 3x3 ring, centre excluded.
    localparam t_offset RING_DX [RING_SIZE] = '{-2'sd1, -2'sd1, -2'sd1, 2'sd0,
                                               2'sd0, 2'sd1, 2'sd1, 2'sd1};
    localparam t_offset RING_DY [RING_SIZE] = '{-2'sd1, 2'sd0, 2'sd1, -2'sd1,
                                               2'sd1, -2'sd1, 2'sd0, 2'sd1};

    typedef enum logic [1:0] {
        CFG_WINDOW = 2'd0,
        CFG_WIDTH  = 2'd1,
        CFG_HEIGHT = 2'd2
    } t_cfg_idx;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_CHECK,
        ST_RING
    } t_state;

    // Row-major map address of a pixel.
    function automatic t_addr pix_addr(input logic [COORD_W-1:0] row,
                                       input logic [COORD_W-1:0] col);
        logic [31:0] lin;
        lin = 32'(row) * 32'(MAX_COLS) + 32'(col);
        return lin[ADDR_W-1:0];
    endfunction

endpackage

FILE: rtl/core/esif_ram.sv
// Generic single-port RAM with a registered, enabled read.
// Depends on nothing.
module esif_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_addr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/core/event_surround_inhibit_filter_unit.sv
// Top level of the surround-inhibit event filter: sequencer, ring address unit,
// configuration registers and result register. Depends on esif_pkg and esif_ram.
//
// Channel   Dir  Contents (lowest bit first)
// s_axis    in   tdata: pixel_x[8:0], pixel_y[17:9], event_time[49:18]; tuser: event_valid
// m_axis    out  tdata: keep[0]
// cfg       in   index 0 surround_window, 1 sensor_width, 2 sensor_height
//
// After reset the timestamp map is swept to zero, one entry a cycle, across all
// MAX_COLS * MAX_ROWS entries; no request is taken during the sweep. For a
// valid request the accept cycle reads the centre pixel, the check state
// compares and writes the first neighbour, and the ring state writes the other
// neighbours in turn; the single map port serialises them. An invalid request
// returns from the check state to idle. A stalled result holds only the check
// state; the next request is accepted while a result waits to be taken.
`include "event_surround_inhibit_filter_unit_defines.svh"

module event_surround_inhibit_filter_unit
    import esif_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Input requests.
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [55:0] i_s_axis_tdata,   // pixel_x, pixel_y, event_time, zero fill
    input  logic [0:0]  i_s_axis_tuser,   // event_valid
    // Results.
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [7:0]  o_m_axis_tdata,   // keep, zero fill
    // Configuration writes.
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [CFG_W-1:0] i_cfg_wdata
);

    t_state r_state, n_state;

    // Configuration registers.
    logic [WINDOW_W-1:0] r_window;
    logic [SIZE_W-1:0]   r_width;
    logic [SIZE_W-1:0]   r_height;

    // Captured request.
    logic [X_W-1:0]    r_x;
    logic [Y_W-1:0]    r_y;
    logic [TIME_W-1:0] r_time;
    logic              r_valid;
    logic              r_ctr_in;

    logic [ADDR_W-1:0] r_clr_cnt;
    logic [RING_W-1:0] r_step;

    logic r_m_valid;
    logic r_keep;

    // Control decoded from the state.
    logic        s_fire;
    logic        out_free;
    logic        ram_we;
    logic        ram_re;
    t_addr       ram_addr;
    logic [TIME_W-1:0] ram_wdata;
    logic [TIME_W-1:0] ram_rdata;
    logic        load_out;
    logic        step_adv;

    // Request fields.
    logic [X_W-1:0]    in_x;
    logic [Y_W-1:0]    in_y;
    logic [TIME_W-1:0] in_time;
    logic              in_valid;
    logic              in_ctr_in;
    t_addr             ctr_addr;

    assign in_x     = i_s_axis_tdata[X_W-1:0];
    assign in_y     = i_s_axis_tdata[X_W+Y_W-1:X_W];
    assign in_time  = i_s_axis_tdata[X_W+Y_W+TIME_W-1:X_W+Y_W];
    assign in_valid = i_s_axis_tuser[0];

    // A pixel beyond the stored array reads as time zero.
    assign in_ctr_in = (32'(in_x) < 32'(MAX_COLS)) && (32'(in_y) < 32'(MAX_ROWS));
    assign ctr_addr  = pix_addr(COORD_W'(in_y), COORD_W'(in_x));

    assign s_fire   = i_s_axis_tvalid && o_s_axis_tready;
    assign out_free = !r_m_valid || i_m_axis_tready;

    // Ring address unit: one neighbour per unstalled cycle, selected by the step counter.
    t_coord            nx_s, ny_s;
    logic [COORD_W-1:0] nx_u, ny_u;
    logic              nbr_ok;
    t_addr             nbr_addr;

    always_comb begin
        nx_s = $signed({2'b00, r_x}) + COORD_W'(RING_DX[r_step]);
        ny_s = $signed({2'b00, r_y}) + COORD_W'(RING_DY[r_step]);
        nx_u = $unsigned(nx_s);
        ny_u = $unsigned(ny_s);
        // Neighbours off the edge are skipped; the area is the configured
        // sensor size clipped to the stored array.
        nbr_ok = !nx_s[COORD_W-1] && !ny_s[COORD_W-1]
              && (nx_u < COORD_W'(r_width))  && (32'(nx_u) < 32'(MAX_COLS))
              && (ny_u < COORD_W'(r_height)) && (32'(ny_u) < 32'(MAX_ROWS));
        nbr_addr = pix_addr(ny_u, nx_u);
    end

    // Exact signed difference against the window.
    logic [TIME_W-1:0]        last_time;
    logic signed [TIME_W:0]   delta;
    logic                     keep_calc;

    always_comb begin
        last_time = r_ctr_in ? ram_rdata : '0;
        delta     = $signed({1'b0, r_time}) - $signed({1'b0, last_time});
        keep_calc = r_valid && (delta >= $signed({{(TIME_W+1-WINDOW_W){1'b0}}, r_window}));
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_CLEAR: begin
                if (r_clr_cnt == ADDR_W'(MAP_DEPTH - 1)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_fire) begin
                    n_state = ST_CHECK;
                end
            end
            ST_CHECK: begin
                if (out_free) begin
                    n_state = r_valid ? ST_RING : ST_IDLE;
                end
            end
            ST_RING: begin
                if (r_step == RING_W'(RING_SIZE - 1)) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_CLEAR;
        endcase
    end

    // State outputs.
    always_comb begin
        o_s_axis_tready = 1'b0;
        ram_we    = 1'b0;
        ram_re    = 1'b0;
        ram_addr  = nbr_addr;
        ram_wdata = r_time;
        load_out  = 1'b0;
        step_adv  = 1'b0;
        unique case (r_state)
            ST_CLEAR: begin
                ram_we    = 1'b1;
                ram_addr  = r_clr_cnt;
                ram_wdata = '0;
            end
            ST_IDLE: begin
                o_s_axis_tready = 1'b1;
                ram_re   = s_fire;
                ram_addr = ctr_addr;
            end
            ST_CHECK: begin
                load_out = out_free;
                step_adv = out_free && r_valid;
                ram_we   = out_free && r_valid && nbr_ok;
            end
            ST_RING: begin
                step_adv = 1'b1;
                ram_we   = nbr_ok;
            end
            default: begin
                ram_we = 1'b0;
            end
        endcase
    end

    esif_ram #(
        .WIDTH(TIME_W),
        .DEPTH(MAP_DEPTH)
    ) u_map (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_re   (ram_re),
        .i_addr (ram_addr),
        .i_wdata(ram_wdata),
        .o_rdata(ram_rdata)
    );

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_CLEAR;
            r_clr_cnt <= '0;
            r_step    <= '0;
            r_m_valid <= 1'b0;
            r_window  <= RESET_WINDOW;
            r_width   <= RESET_WIDTH;
            r_height  <= RESET_HEIGHT;
        end else begin
            r_state <= n_state;
            if (r_state == ST_CLEAR) begin
                r_clr_cnt <= r_clr_cnt + 1'b1;
            end
            if (s_fire) begin
                r_step <= '0;
            end else if (step_adv) begin
                r_step <= r_step + 1'b1;
            end
            if (load_out) begin
                r_m_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_m_valid <= 1'b0;
            end
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_WINDOW: r_window <= i_cfg_wdata[WINDOW_W-1:0];
                    CFG_WIDTH:  r_width  <= i_cfg_wdata[SIZE_W-1:0];
                    CFG_HEIGHT: r_height <= i_cfg_wdata[SIZE_W-1:0];
                    default:    r_window <= r_window;
                endcase
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (s_fire) begin
            r_x      <= in_x;
            r_y      <= in_y;
            r_time   <= in_time;
            r_valid  <= in_valid;
            r_ctr_in <= in_ctr_in;
        end
        if (load_out) begin
            r_keep <= keep_calc;
        end
    end

    assign o_m_axis_tvalid = r_m_valid;
    assign o_m_axis_tdata  = {7'b0, r_keep};

    `ESIF_ASSERT_SAME(a_no_req_in_clear, r_state == ST_CLEAR, !o_s_axis_tready, "request taken during map clear")
    `ESIF_ASSERT_SAME(a_port_exclusive, ram_we, !ram_re, "map read and write in one cycle")
    `ESIF_ASSERT_NEXT(a_accept_to_check, s_fire, r_state == ST_CHECK, "accept not followed by check")
    `ESIF_ASSERT_SAME(a_ring_needs_valid, r_state == ST_RING, r_valid, "ring writes for invalid event")

endmodule
